// ----- design/sdtf_pkg.sv -----
// Shared types and constants for the signed decimal text formatter.
package sdtf_pkg;

  // Width of the number being formatted
  localparam int unsigned MagW = 32;
  // Width of the digit count field
  localparam int unsigned CountW = 4;
  // Default limit on digits per text
  localparam int unsigned MaxDigitsDefault = 9;
  // Hard limit: sign plus nine digits fills a text
  localparam int unsigned TextDigitLimit = 9;
  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // ASCII codes
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = 8'h30;

  // Classified item handed from front to back
  typedef struct packed {
    logic              neg;
    logic [MagW-1:0]   mag;
    logic [CountW-1:0] ndig;
  } item_t;

endpackage

// ----- design/sdtf_front.sv -----
// Front end: takes the sign, magnitude and effective digit count of an item.
module sdtf_front #(
  parameter int unsigned MAX_DIGITS = sdtf_pkg::MaxDigitsDefault
) (
  input  logic signed [sdtf_pkg::MagW-1:0]   value_i,
  input  logic        [sdtf_pkg::CountW-1:0] digit_count_i,
  output sdtf_pkg::item_t                    item_o
);

  logic                        neg;
  logic [sdtf_pkg::MagW-1:0]   raw;
  logic                        count_ok;

  assign raw = sdtf_pkg::MagW'(unsigned'(value_i));
  assign neg = raw[sdtf_pkg::MagW-1];

  // Count of zero or above either limit emits the sign only
  assign count_ok = (digit_count_i != '0)
                 && (int'(digit_count_i) <= int'(MAX_DIGITS))
                 && (int'(digit_count_i) <= int'(sdtf_pkg::TextDigitLimit));

  // Two's complement negate; the most negative value wraps to 2^31 unsigned
  always_comb begin
    item_o.neg  = neg;
    item_o.mag  = neg ? (sdtf_pkg::MagW'(0) - raw) : raw;
    item_o.ndig = count_ok ? digit_count_i : '0;
  end

endmodule

// ----- design/sdtf_queue.sv -----
// Short item queue between the front and the back.
module sdtf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sdtf_pkg::item_t item_i,
  input  logic            pop_i,
  output sdtf_pkg::item_t item_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (sdtf_pkg::QueueDepth > 1) ? $clog2(sdtf_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(sdtf_pkg::QueueDepth + 1);

  sdtf_pkg::item_t mem_q [sdtf_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(sdtf_pkg::QueueDepth));
  assign item_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(sdtf_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(sdtf_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- design/sdtf_back.sv -----
// Back end: shift-add binary to BCD conversion, then character emission.
module sdtf_back #(
  parameter int unsigned MAX_DIGITS = sdtf_pkg::MaxDigitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sdtf_pkg::item_t item_i,
  input  logic            avail_i,
  output logic            pop_o,
  output logic [7:0]      text_char_o,
  output logic            last_char_o,
  output logic            text_valid_o
);

  // Digits kept; conversion is taken modulo ten to this many places
  localparam int unsigned StoreDepth = MAX_DIGITS;
  localparam int unsigned IdxW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned StepW      = $clog2(sdtf_pkg::MagW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  state_e                        state_q;
  logic [StepW-1:0]              step_q;
  logic [IdxW-1:0]               idx_q;
  logic [7:0]                    char_q;
  logic                          last_q;
  logic                          valid_q;

  logic                          neg_q;
  logic [sdtf_pkg::CountW-1:0]   ndig_q;
  logic [sdtf_pkg::MagW-1:0]     mag_q;
  logic [3:0]                    store_q [StoreDepth];
  logic [3:0]                    adj     [StoreDepth];
  logic [3:0]                    store_d [StoreDepth];

  assign pop_o = (state_q == ST_IDLE) && avail_i;

  // Add-3 correction per digit, then shift the next magnitude bit in
  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      adj[i] = (store_q[i] >= 4'd5) ? store_q[i] + 4'd3 : store_q[i];
    end
    for (int i = 0; i < StoreDepth; i++) begin
      if (i == 0) begin
        store_d[i] = {adj[i][2:0], mag_q[sdtf_pkg::MagW-1]};
      end else begin
        store_d[i] = {adj[i][2:0], adj[i-1][3]};
      end
    end
  end

  // Datapath: load on pop, convert one bit per cycle
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      neg_q  <= item_i.neg;
      ndig_q <= item_i.ndig;
      mag_q  <= item_i.mag;
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= 4'd0;
      end
    end else if (state_q == ST_CONV) begin
      mag_q   <= {mag_q[sdtf_pkg::MagW-2:0], 1'b0};
      store_q <= store_d;
    end
  end

  // Sequencer with registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
      char_q  <= '0;
      last_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (avail_i) begin
            step_q  <= '0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(sdtf_pkg::MagW - 1)) begin
            state_q <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          valid_q <= 1'b1;
          char_q  <= neg_q ? sdtf_pkg::CharMinus : sdtf_pkg::CharSpace;
          last_q  <= (ndig_q == '0);
          idx_q   <= IdxW'(ndig_q - 1'b1);
          state_q <= (ndig_q == '0) ? ST_IDLE : ST_DIGIT;
        end
        ST_DIGIT: begin
          valid_q <= 1'b1;
          char_q  <= sdtf_pkg::CharZero + {4'd0, store_q[idx_q]};
          last_q  <= (idx_q == '0);
          idx_q   <= idx_q - 1'b1;
          if (idx_q == '0) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign text_char_o  = char_q;
  assign last_char_o  = last_q;
  assign text_valid_o = valid_q;

endmodule

// ----- design/signed_decimal_text_formatter.sv -----
// Top level: signed 32-bit number to ASCII sign and decimal digits.
// Path: queue, shift-add conversion, sign character; digits follow back to back.
// The back end takes no new item until the current text is out; its 32-step shift-add
// BCD conversion sets the pace, and a two-entry queue holds items meanwhile.
// Reset: asynchronous, active low; clears the queue and the sequencer.
// The receiver cannot stall: each character shows for one cycle with text_valid_o.
module signed_decimal_text_formatter #(
  parameter int unsigned MAX_DIGITS = sdtf_pkg::MaxDigitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [sdtf_pkg::MagW-1:0]   value_i,
  input  logic        [sdtf_pkg::CountW-1:0] digit_count_i,
  output logic        [7:0]                  text_char_o,
  output logic                               last_char_o,
  output logic                               text_valid_o
);

  sdtf_pkg::item_t front_item, head_item;
  logic            q_empty, q_full, q_push, q_pop;

  assign busy   = q_full;
  assign q_push = start && !busy;

  // Classify
  sdtf_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .value_i      (value_i),
    .digit_count_i(digit_count_i),
    .item_o       (front_item)
  );

  // Decouple
  sdtf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (front_item),
    .pop_i  (q_pop),
    .item_o (head_item),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // Convert and emit
  sdtf_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .avail_i     (!q_empty),
    .pop_o       (q_pop),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o),
    .text_valid_o(text_valid_o)
  );

endmodule

// ----- design/sdtf_checker.sv -----
// Port-level checks on the formatter's character stream, bound to the top level.
module sdtf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] text_char_o,
  input logic       last_char_o,
  input logic       text_valid_o
);

  logic is_sign, is_digit;

  assign is_sign  = (text_char_o == sdtf_pkg::CharMinus) || (text_char_o == sdtf_pkg::CharSpace);
  assign is_digit = (text_char_o >= sdtf_pkg::CharZero) && (text_char_o <= 8'h39);

  // Every character is a sign or a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_valid_o |-> (is_sign || is_digit))
    else $error("sdtf: character outside sign and digit set");

  // A text does not pause before its last character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_valid_o && !last_char_o) |=> text_valid_o)
    else $error("sdtf: gap inside a text");

  // A sign that is not last is followed by a digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_valid_o && is_sign && !last_char_o) |=> is_digit)
    else $error("sdtf: sign not followed by a digit");

  // A digit always continues a text already in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_valid_o && is_digit) |-> ($past(text_valid_o) && !$past(last_char_o)))
    else $error("sdtf: digit without a preceding character");

endmodule

bind signed_decimal_text_formatter sdtf_checker u_sdtf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .text_char_o (text_char_o),
  .last_char_o (last_char_o),
  .text_valid_o(text_valid_o)
);

// ----- test/tb_signed_decimal_text_formatter.sv -----
// Testbench for the signed decimal text formatter: directed and random numbers, checked per character.
module tb_signed_decimal_text_formatter;

  localparam int unsigned MaxDigits   = sdtf_pkg::MaxDigitsDefault;
  localparam int unsigned RandomItems = 330;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 60;

  // One character of formatted text
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // Predicts the text of each accepted number and checks characters in order
  class text_scoreboard;
    text_char_t  expected_text[$];
    int unsigned mismatches;

    task report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    // Sign character, then the low ndig decimal digits of the magnitude
    function void note_number(input logic [sdtf_pkg::MagW-1:0] value,
                              input logic [sdtf_pkg::CountW-1:0] count);
      logic [sdtf_pkg::MagW-1:0] mag;
      longint unsigned           mag_wide;
      longint unsigned           scale;
      int unsigned               cnt;
      int unsigned               ndig;
      int unsigned               p;
      int unsigned               i;
      text_char_t                c;
      mag      = value[sdtf_pkg::MagW-1] ? (32'd0 - value) : value;
      mag_wide = mag;
      cnt      = int'(count);
      ndig     = (cnt >= 1 && cnt <= MaxDigits && cnt <= sdtf_pkg::TextDigitLimit) ? cnt : 0;
      c.ch     = value[sdtf_pkg::MagW-1] ? sdtf_pkg::CharMinus : sdtf_pkg::CharSpace;
      c.last   = (ndig == 0);
      expected_text.push_back(c);
      for (p = 0; p < ndig; p++) begin
        scale = 1;
        for (i = 0; i + 1 + p < ndig; i++) scale = scale * 10;
        c.ch   = sdtf_pkg::CharZero + 8'((mag_wide / scale) % 10);
        c.last = (p + 1 == ndig);
        expected_text.push_back(c);
      end
    endfunction

    task check_char(input logic [7:0] ch, input logic last);
      text_char_t want;
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b", ch, last));
      end else begin
        want = expected_text.pop_front();
        if (ch !== want.ch)
          report_mismatch($sformatf("text_char %h, expected %h", ch, want.ch));
        if (last !== want.last)
          report_mismatch($sformatf("last_char %b, expected %b (char %h)", last, want.last,
                                    want.ch));
      end
    endtask
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start;
  logic                               busy;
  logic signed [sdtf_pkg::MagW-1:0]   value_i;
  logic        [sdtf_pkg::CountW-1:0] digit_count_i;
  logic        [7:0]                  text_char_o;
  logic                               last_char_o;
  logic                               text_valid_o;

  text_scoreboard sb;
  int unsigned    cycle_count;

  signed_decimal_text_formatter #(
    .MAX_DIGITS(MaxDigits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .digit_count_i(digit_count_i),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o),
    .text_valid_o (text_valid_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Character monitor: each strobe is one result
  always @(posedge clk_i) begin
    if (rst_ni && text_valid_o) sb.check_char(text_char_o, last_char_o);
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one item and hold it until accepted
  task send_number(input logic [sdtf_pkg::MagW-1:0] value,
                   input logic [sdtf_pkg::CountW-1:0] count);
    start         <= 1'b1;
    value_i       <= value;
    digit_count_i <= count;
    do @(posedge clk_i); while (busy);
    sb.note_number(value, count);
  endtask

  // Drop start and drive noise on the fields
  task idle_cycles(input int unsigned n);
    start         <= 1'b0;
    value_i       <= $urandom;
    digit_count_i <= sdtf_pkg::CountW'($urandom_range(15, 0));
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [sdtf_pkg::MagW-1:0] random_value();
    logic [sdtf_pkg::MagW-1:0] v;
    case ($urandom_range(9, 0))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = $urandom_range(99, 0);
      3: v = 32'd0 - $urandom_range(99, 1);
      4: v = $urandom_range(999999999, 100000000);
      5: v = 32'd0 - $urandom_range(999999999, 1);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [sdtf_pkg::CountW-1:0] random_count();
    if ($urandom_range(99, 0) < 80) return sdtf_pkg::CountW'($urandom_range(9, 1));
    if ($urandom_range(1, 0) == 0) return '0;
    return sdtf_pkg::CountW'($urandom_range(15, 10));
  endfunction

  // Stimulus
  initial begin
    int unsigned n;
    int unsigned gap;
    sb            = new();
    cycle_count   = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    value_i       = '0;
    digit_count_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: count extremes, sign extremes, dropped high digits
    for (n = 0; n <= 10; n++) send_number(32'd0, sdtf_pkg::CountW'(n));
    send_number(32'd0, 4'd15);
    send_number(32'hFFFF_FFFF, 4'd1);
    send_number(32'h7FFF_FFFF, 4'd9);
    send_number(32'h7FFF_FFFF, 4'd10);
    send_number(32'h8000_0000, 4'd9);
    send_number(32'h8000_0000, 4'd1);
    send_number(32'h8000_0000, 4'd0);
    send_number(32'd999999999, 4'd9);
    send_number(32'd0 - 32'd1000000000, 4'd9);
    send_number(32'd12345, 4'd3);
    send_number(32'd0 - 32'd7, 4'd15);
    send_number(32'd5, 4'd9);
    idle_cycles(80);

    // Random; a calm stretch in the middle keeps start high back to back
    for (n = 0; n < RandomItems; n++) begin
      gap = 0;
      if ((n < 120 || n >= 200) && $urandom_range(99, 0) < 32)
        gap = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 5) : $urandom_range(4, 1);
      if (gap != 0) idle_cycles(gap);
      send_number(random_value(), random_count());
    end
    start <= 1'b0;

    // Drain
    while (sb.expected_text.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.expected_text.size() != 0)
      sb.report_mismatch($sformatf("%0d characters never arrived", sb.expected_text.size()));

    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- signed_decimal_text_formatter.f -----
design/sdtf_pkg.sv
design/sdtf_front.sv
design/sdtf_queue.sv
design/sdtf_back.sv
design/signed_decimal_text_formatter.sv
design/sdtf_checker.sv
test/tb_signed_decimal_text_formatter.sv
